>>> rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared constants and control types for the streaming prefix-function block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

  // string capacity in characters
  localparam int MAX_LEN  = 65536;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int LEN_W    = $clog2(MAX_LEN + 1);

  // payload field widths
  localparam int CHAR_W   = 8;
  localparam int BORDER_W = 16;
  localparam int POS_W    = 17;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // item taken this cycle
    logic store_first;  // first character of a string: store, border 0
    logic start;        // begin link walk from current border
    logic step;         // mismatch: follow the failure link
    logic finish;       // walk done: store and emit result
    logic emit_ovf;     // string full: emit overflow result
  } pfs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic b_zero;
    logic out_busy;
  } pfs_stat_t;

endpackage

`default_nettype wire

>>> rtl/pfs_if.sv
// ----------------------------------------------------------------------------
// pfs_in_if / pfs_out_if
// Valid/ready channels for characters in and border results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       first;

  modport source (output valid, output char_in, output first, input ready);
  modport sink   (input valid, input char_in, input first, output ready);
endinterface

interface pfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] border_len;
  logic [16:0] position;
  logic        overflow;

  modport source (output valid, output border_len, output position, output overflow,
                  input ready);
  modport sink   (input valid, input border_len, input position, input overflow,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/pfs_ram.sv
// ----------------------------------------------------------------------------
// pfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/pfs_dp.sv
// ----------------------------------------------------------------------------
// pfs_dp
// Datapath: character and border stores, walk register, length, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfs_dp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire pfs_pkg::pfs_cmd_t       cmd,
  output      pfs_pkg::pfs_stat_t      stat,
  input  wire logic [7:0]              char_in,
  input  wire logic                    first,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [15:0]             border_len,
  output      logic [16:0]             position,
  output      logic                    overflow
);

  import pfs_pkg::*;

  logic [CHAR_W-1:0] c_reg;
  addr_t             b;
  addr_t             cur;
  len_t              len;
  len_t              len_eff;

  addr_t             char_raddr;
  addr_t             bord_raddr;
  logic [CHAR_W-1:0] char_rdata;
  addr_t             bord_rdata;

  logic              we;
  addr_t             waddr;
  logic [CHAR_W-1:0] wchar;
  addr_t             wbord;
  addr_t             nb;
  len_t              len_inc;

  assign len_eff = first ? '0 : len;
  assign nb      = stat.match ? addr_t'(b + addr_t'(1)) : '0;
  assign len_inc = len_t'(len + len_t'(1));

  assign stat.full     = (len_eff == len_t'(MAX_LEN));
  assign stat.empty    = (len_eff == '0);
  assign stat.match    = (c_reg == char_rdata);
  assign stat.b_zero   = (b == '0);
  assign stat.out_busy = out_valid && !out_ready;

  // read address: current border at start, failure link on a mismatch
  always_comb begin
    priority if (cmd.start) begin
      char_raddr = cur;
    end else if (cmd.step) begin
      char_raddr = bord_rdata;
    end else begin
      char_raddr = b;
    end
  end
  // link for border b lives at b-1; wraps harmlessly when b is zero
  assign bord_raddr = addr_t'(char_raddr - addr_t'(1));

  always_comb begin
    we    = cmd.store_first || cmd.finish;
    waddr = cmd.store_first ? '0 : len[ADDR_W-1:0];
    wchar = cmd.store_first ? char_in : c_reg;
    wbord = cmd.store_first ? '0 : nb;
  end

  pfs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_char_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wchar),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  pfs_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_bord_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wbord),
    .raddr (bord_raddr),
    .rdata (bord_rdata)
  );

  // a first flag always lands in store_first, which restarts the string
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.store_first) begin
        len <= len_t'(1);
        cur <= '0;
      end
      if (cmd.finish) begin
        len <= len_inc;
        cur <= nb;
      end
      if (cmd.store_first || cmd.finish || cmd.emit_ovf) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      c_reg <= char_in;
      b     <= cur;
    end else if (cmd.step) begin
      b <= bord_rdata;
    end
    if (cmd.store_first) begin
      border_len <= '0;
      position   <= POS_W'(1);
      overflow   <= 1'b0;
    end else if (cmd.finish) begin
      border_len <= BORDER_W'(nb);
      position   <= POS_W'(len_inc);
      overflow   <= 1'b0;
    end else if (cmd.emit_ovf) begin
      border_len <= '0;
      position   <= '0;
      overflow   <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pfs_ctrl.sv
// ----------------------------------------------------------------------------
// pfs_ctrl
// Controller: sequences accept, failure-link walk and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire pfs_pkg::pfs_stat_t stat,
  output      pfs_pkg::pfs_cmd_t  cmd
);

  import pfs_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_CMP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        // result slot must be free or draining before a new item
        in_ready   = !stat.out_busy;
        cmd.accept = in_valid && !stat.out_busy;
        if (cmd.accept) begin
          priority if (stat.full) begin
            cmd.emit_ovf = 1'b1;
          end else if (stat.empty) begin
            cmd.store_first = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (stat.match || stat.b_zero) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/prefix_function_stream.sv
// ----------------------------------------------------------------------------
// prefix_function_stream
// Streaming prefix (failure) function: one border length per character.
// ----------------------------------------------------------------------------
// Input channel in_ch carries a character and a first flag that starts a new
// string. Output channel out_ch gives one result per item: the longest proper
// border of the prefix ending at that character, its one-based position, and
// an overflow flag once the string holds MAX_LEN characters (border and
// position then read 0).
// Timing: the first character of a string, and an overflow item, give a
// result in the cycle after acceptance. Any other character first follows
// k failure links before its result is registered; each link costs one read of
// the character and border RAMs, whose registered read port sets the pace.
// Averaged over a string k stays below one.
// One item is in flight at a time; in_ch.ready is high again the cycle after
// the result is registered, provided the result register is free or draining.
// A stalled receiver holds the result; in_ch.ready stays low until it is
// taken. Reset clears the string length, so the next item continues an
// empty string; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prefix_function_stream (
  input  wire logic clk,
  input  wire logic rst,
  pfs_in_if.sink    in_ch,
  pfs_out_if.source out_ch
);

  import pfs_pkg::*;

  pfs_cmd_t  cmd;
  pfs_stat_t stat;

  pfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .char_in    (in_ch.char_in),
    .first      (in_ch.first),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .border_len (out_ch.border_len),
    .position   (out_ch.position),
    .overflow   (out_ch.overflow)
  );

endmodule

`default_nettype wire
